FILE: design/ltgq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltgq_pkg
// Shared types and codes for the lock table with grant queue and revoke scan.
// ----------------------------------------------------------------------------
package ltgq_pkg;

    typedef enum logic [1:0] {
        KIND_ACQUIRE = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_TICK    = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_RETRY      = 3'd1;
    localparam logic [2:0] ST_TABLE_FULL = 3'd2;
    localparam logic [2:0] ST_QUEUE_FULL = 3'd3;
    localparam logic [2:0] ST_UNKNOWN    = 3'd4;

    localparam logic [1:0] MSG_NONE   = 2'd0;
    localparam logic [1:0] MSG_GRANT  = 2'd1;
    localparam logic [1:0] MSG_REVOKE = 2'd2;

    // Revokes sent by one tick at most
    localparam int MAX_RESULTS = 16;
    localparam int SENT_W      = 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_EXEC,
        S_READ,
        S_SCAN
    } state_t;

    typedef enum logic [2:0] {
        UPD_NONE,
        UPD_ALLOC,
        UPD_TAKE,
        UPD_ENQ,
        UPD_FREE,
        UPD_HANDOFF,
        UPD_REVOKE
    } upd_op_t;

    typedef struct packed {
        logic hit;
        logic found;
    } lookup_t;

endpackage

FILE: design/lock_table_grant_queue_revoke.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lock_table_grant_queue_revoke
// Lock manager: entry table with per-lock waiter FIFOs held in a RAM,
// grant on release and revoke scan on tick.
// ----------------------------------------------------------------------------
// An acquire and most releases go through the lookup and execute states; a release
// that hands the lock on also reads the waiter RAM in the read state before its result.
// A tick walks the table one entry a cycle, but holds at an entry to revoke while
// the output register cannot take the revoke. One item at a time; the next is
// taken once its results are in the output register.
// Reset empties the table at once; the waiter RAM needs no clearing.
module lock_table_grant_queue_revoke #(
    parameter int LOCK_ENTRIES = 16,
    parameter int WAIT_DEPTH   = 8,
    parameter int CLIENT_BITS  = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // lock_id[63:0], client_id[71:64]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // status[2:0], target_client[10:3],
                                   // message_lock[74:11], zero pad[79:75]
    output logic [1:0]  m_tuser,   // message[1:0]
    output logic        m_tlast
);
    import ltgq_pkg::*;

    localparam int IDX_W  = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
    localparam int HEAD_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WAIT_DEPTH + 1);
    localparam int DEPTH  = LOCK_ENTRIES * WAIT_DEPTH;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W = CNT_W + 1;

    state_t state_reg, state_next;
    kind_t  kind_reg;
    logic [63:0]            key_reg;
    logic [CLIENT_BITS-1:0] client_reg;
    logic [IDX_W-1:0]       scan_reg, scan_next;
    logic [SENT_W-1:0]      sent_reg, sent_next;

    logic        out_valid_reg;
    logic [2:0]  status_reg;
    logic [1:0]  msg_reg;
    logic [7:0]  target_reg;
    logic [63:0] mlock_reg;
    logic        last_reg;

    logic        emit;
    logic [2:0]  emit_status;
    logic [1:0]  emit_msg;
    logic [7:0]  emit_target;
    logic [63:0] emit_lock;
    logic        emit_last;
    logic        out_free;

    lookup_t                lookup;
    logic [IDX_W-1:0]       idx;
    logic [IDX_W-1:0]       rd_idx;
    logic [CLIENT_BITS-1:0] rd_holder;
    logic [63:0]            rd_lock;
    logic                   rd_free;
    logic [HEAD_W-1:0]      rd_head;
    logic [CNT_W-1:0]       rd_count;
    logic [LOCK_ENTRIES-1:0] qual;
    logic [LOCK_ENTRIES-1:0] above;
    upd_op_t                upd_op;
    logic [CLIENT_BITS-1:0] upd_holder;

    logic                   ram_we, ram_re;
    logic [ADDR_W-1:0]      ram_waddr, ram_raddr, base_addr;
    logic [CLIENT_BITS-1:0] ram_rdata;
    logic [CLIENT_BITS-1:0] ram_wdata_c;
    logic [SLOT_W-1:0]      slot_sum;
    logic [HEAD_W-1:0]      slot;

    logic [CLIENT_BITS+7:0] client_ext;
    logic [CLIENT_BITS+7:0] holder_ext;
    logic [CLIENT_BITS+7:0] waiter_ext;

    assign client_ext = {{CLIENT_BITS{1'b0}}, s_tdata[71:64]};
    assign holder_ext = {8'd0, rd_holder};
    assign waiter_ext = {8'd0, ram_rdata};

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    assign rd_idx = (state_reg == S_SCAN) ? scan_reg : idx;

    // Queue slot after the last waiter, wrapped at the depth
    assign slot_sum  = SLOT_W'(rd_head) + SLOT_W'(rd_count);
    assign slot      = (slot_sum >= SLOT_W'(WAIT_DEPTH))
                     ? HEAD_W'(slot_sum - SLOT_W'(WAIT_DEPTH)) : HEAD_W'(slot_sum);
    assign base_addr = ADDR_W'(idx) * ADDR_W'(WAIT_DEPTH);
    assign ram_waddr = base_addr + ADDR_W'(slot);
    assign ram_raddr = base_addr + ADDR_W'(rd_head);
    assign ram_wdata_c = client_reg;

    always_comb begin
        for (int i = 0; i < LOCK_ENTRIES; i++) begin
            above[i] = (i > int'(scan_reg));
        end
    end

    ltgq_table #(
        .LOCK_ENTRIES (LOCK_ENTRIES),
        .WAIT_DEPTH   (WAIT_DEPTH),
        .CLIENT_BITS  (CLIENT_BITS)
    ) u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .lookup_en  (state_reg == S_LOOKUP),
        .key        (key_reg),
        .lookup     (lookup),
        .idx        (idx),
        .rd_idx     (rd_idx),
        .rd_holder  (rd_holder),
        .rd_lock    (rd_lock),
        .rd_free    (rd_free),
        .rd_head    (rd_head),
        .rd_count   (rd_count),
        .qual       (qual),
        .upd_op     (upd_op),
        .upd_idx    (rd_idx),
        .upd_holder (upd_holder)
    );

    ltgq_ram #(
        .WIDTH (CLIENT_BITS),
        .DEPTH (DEPTH)
    ) u_waiters (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata_c),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: state_next = S_EXEC;
            S_EXEC: begin
                if (kind_reg == KIND_RELEASE && lookup.hit && rd_count != '0) begin
                    state_next = S_READ;
                end else if (kind_reg == KIND_TICK && qual != '0) begin
                    state_next = S_SCAN;
                end else if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_READ: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                if (qual[scan_reg] && out_free && emit_last) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs of each state: result, table update, RAM access
    always_comb begin
        emit        = 1'b0;
        emit_status = ST_OK;
        emit_msg    = MSG_NONE;
        emit_target = '0;
        emit_lock   = key_reg;
        emit_last   = 1'b1;
        upd_op      = UPD_NONE;
        upd_holder  = client_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        scan_next   = scan_reg;
        sent_next   = sent_reg;
        case (state_reg)
            S_EXEC: begin
                scan_next = '0;
                sent_next = '0;
                case (kind_reg)
                    KIND_ACQUIRE: begin
                        emit = out_free;
                        if (!lookup.found) begin
                            emit_status = ST_TABLE_FULL;
                        end else if (!lookup.hit) begin
                            upd_op = emit ? UPD_ALLOC : UPD_NONE;
                        end else if (rd_free) begin
                            upd_op = emit ? UPD_TAKE : UPD_NONE;
                        end else if (rd_count >= CNT_W'(WAIT_DEPTH)) begin
                            emit_status = ST_QUEUE_FULL;
                        end else begin
                            emit_status = ST_RETRY;
                            upd_op      = emit ? UPD_ENQ : UPD_NONE;
                            ram_we      = emit;
                        end
                    end
                    KIND_RELEASE: begin
                        if (!lookup.hit) begin
                            emit        = out_free;
                            emit_status = ST_UNKNOWN;
                        end else if (rd_count == '0) begin
                            emit   = out_free;
                            upd_op = emit ? UPD_FREE : UPD_NONE;
                        end else begin
                            ram_re = 1'b1;
                        end
                    end
                    KIND_TICK: begin
                        if (qual == '0) begin
                            emit      = out_free;
                            emit_lock = '0;
                        end
                    end
                    default: begin
                        emit      = out_free;
                        emit_lock = '0;
                    end
                endcase
            end
            S_READ: begin
                emit        = out_free;
                emit_msg    = MSG_GRANT;
                emit_target = waiter_ext[7:0];
                upd_holder  = ram_rdata;
                upd_op      = emit ? UPD_HANDOFF : UPD_NONE;
            end
            S_SCAN: begin
                emit_msg    = MSG_REVOKE;
                emit_target = holder_ext[7:0];
                emit_lock   = rd_lock;
                emit_last   = (sent_reg == SENT_W'(MAX_RESULTS - 1))
                            || ((qual & above) == '0);
                if (qual[scan_reg]) begin
                    emit   = out_free;
                    upd_op = emit ? UPD_REVOKE : UPD_NONE;
                    if (emit) begin
                        scan_next = scan_reg + IDX_W'(1);
                        sent_next = sent_reg + SENT_W'(1);
                    end
                end else begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            scan_reg      <= '0;
            sent_reg      <= '0;
        end else begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            sent_reg  <= sent_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg   <= kind_t'(s_tuser);
            key_reg    <= s_tdata[63:0];
            client_reg <= client_ext[CLIENT_BITS-1:0];
        end
        if (emit) begin
            status_reg <= emit_status;
            msg_reg    <= emit_msg;
            target_reg <= emit_target;
            mlock_reg  <= emit_lock;
            last_reg   <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, mlock_reg, target_reg, status_reg};
    assign m_tuser  = msg_reg;
    assign m_tlast  = last_reg;

endmodule

FILE: design/ltgq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltgq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ltgq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/ltgq_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltgq_table
// Lock entry table: id match, first free slot, per-entry holder and queue
// pointers, revoke candidates.
// ----------------------------------------------------------------------------
module ltgq_table #(
    parameter int LOCK_ENTRIES = 16,
    parameter int WAIT_DEPTH   = 8,
    parameter int CLIENT_BITS  = 8,
    localparam int IDX_W  = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1,
    localparam int HEAD_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1,
    localparam int CNT_W  = $clog2(WAIT_DEPTH + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          lookup_en,
    input  logic [63:0]                   key,
    output ltgq_pkg::lookup_t             lookup,
    output logic [IDX_W-1:0]              idx,
    input  logic [IDX_W-1:0]              rd_idx,
    output logic [CLIENT_BITS-1:0]        rd_holder,
    output logic [63:0]                   rd_lock,
    output logic                          rd_free,
    output logic [HEAD_W-1:0]             rd_head,
    output logic [CNT_W-1:0]              rd_count,
    output logic [LOCK_ENTRIES-1:0]       qual,
    input  ltgq_pkg::upd_op_t             upd_op,
    input  logic [IDX_W-1:0]              upd_idx,
    input  logic [CLIENT_BITS-1:0]        upd_holder
);
    import ltgq_pkg::*;

    logic                   valid_reg   [LOCK_ENTRIES];
    logic [63:0]            lock_reg    [LOCK_ENTRIES];
    logic [CLIENT_BITS-1:0] holder_reg  [LOCK_ENTRIES];
    logic                   free_reg    [LOCK_ENTRIES];
    logic                   revoked_reg [LOCK_ENTRIES];
    logic [HEAD_W-1:0]      head_reg    [LOCK_ENTRIES];
    logic [CNT_W-1:0]       count_reg   [LOCK_ENTRIES];

    lookup_t          lookup_reg, lookup_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             hit_c, free_c;
    logic [IDX_W-1:0] hit_idx_c, free_idx_c;
    logic [HEAD_W-1:0] head_inc;

    always_comb begin
        hit_c      = 1'b0;
        free_c     = 1'b0;
        hit_idx_c  = '0;
        free_idx_c = '0;
        for (int i = LOCK_ENTRIES - 1; i >= 0; i--) begin
            if (valid_reg[i] && (lock_reg[i] == key)) begin
                hit_c     = 1'b1;
                hit_idx_c = IDX_W'(i);
            end
            if (!valid_reg[i]) begin
                free_c     = 1'b1;
                free_idx_c = IDX_W'(i);
            end
        end
        lookup_next.hit   = hit_c;
        lookup_next.found = hit_c | free_c;
        idx_next          = hit_c ? hit_idx_c : free_idx_c;
    end

    always_ff @(posedge aclk) begin
        if (lookup_en) begin
            lookup_reg <= lookup_next;
            idx_reg    <= idx_next;
        end
    end

    assign lookup = lookup_reg;
    assign idx    = idx_reg;

    always_comb begin
        for (int i = 0; i < LOCK_ENTRIES; i++) begin
            qual[i] = valid_reg[i] && (count_reg[i] != '0) && !revoked_reg[i];
        end
    end

    assign rd_holder = holder_reg[rd_idx];
    assign rd_lock   = lock_reg[rd_idx];
    assign rd_free   = free_reg[rd_idx];
    assign rd_head   = head_reg[rd_idx];
    assign rd_count  = count_reg[rd_idx];

    // Wrap the read slot at the queue depth
    assign head_inc = (head_reg[upd_idx] == HEAD_W'(WAIT_DEPTH - 1)) ? '0
                    : head_reg[upd_idx] + HEAD_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LOCK_ENTRIES; i++) begin
                valid_reg[i]   <= 1'b0;
                free_reg[i]    <= 1'b0;
                revoked_reg[i] <= 1'b0;
                head_reg[i]    <= '0;
                count_reg[i]   <= '0;
            end
        end else begin
            case (upd_op)
                UPD_ALLOC: begin
                    valid_reg[upd_idx]   <= 1'b1;
                    lock_reg[upd_idx]    <= key;
                    holder_reg[upd_idx]  <= upd_holder;
                    free_reg[upd_idx]    <= 1'b0;
                    revoked_reg[upd_idx] <= 1'b0;
                    head_reg[upd_idx]    <= '0;
                    count_reg[upd_idx]   <= '0;
                end
                UPD_TAKE: begin
                    holder_reg[upd_idx] <= upd_holder;
                    free_reg[upd_idx]   <= 1'b0;
                end
                UPD_ENQ: begin
                    count_reg[upd_idx] <= count_reg[upd_idx] + CNT_W'(1);
                end
                UPD_FREE: begin
                    free_reg[upd_idx]    <= 1'b1;
                    revoked_reg[upd_idx] <= 1'b0;
                end
                UPD_HANDOFF: begin
                    holder_reg[upd_idx]  <= upd_holder;
                    free_reg[upd_idx]    <= 1'b0;
                    revoked_reg[upd_idx] <= 1'b0;
                    head_reg[upd_idx]    <= head_inc;
                    count_reg[upd_idx]   <= count_reg[upd_idx] - CNT_W'(1);
                end
                UPD_REVOKE: begin
                    revoked_reg[upd_idx] <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lock table: a directed table of requests, then
// random acquire/release/tick/none traffic over a small set of lock ids, checked
// transfer by transfer against a behavioural model of the table, under
// several phases of source gaps and sink back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    import ltgq_pkg::*;

    localparam int  NENT       = 16;
    localparam int  QDEPTH     = 8;
    localparam int  CYCLE_MAX  = 400000;
    localparam int  DRAIN_WAIT = 40;
    localparam int  N_RANDOM   = 108;
    localparam int  EXP_DEPTH  = 64;
    localparam int  DIR_MAX    = 32;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  message;
        logic [7:0]  target;
        logic [63:0] lock;
        logic        last;
    } lock_result_t;

    typedef struct {
        kind_t        kind;
        logic [63:0]  lock;
        logic [7:0]   client;
        logic         known;
        lock_result_t res;
    } lock_request_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    lock_table_grant_queue_revoke dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // model state
    logic        tb_valid   [NENT];
    logic [63:0] tb_lock    [NENT];
    logic [7:0]  tb_holder  [NENT];
    logic        tb_free    [NENT];
    logic        tb_revoked [NENT];
    logic [7:0]  tb_waiters [NENT][QDEPTH];
    int          tb_head    [NENT];
    int          tb_count   [NENT];

    // expected results, oldest at exp_rd
    lock_result_t  exp_q [EXP_DEPTH];
    int            exp_wr;
    int            exp_rd;
    lock_request_t directed [DIR_MAX];
    int            n_dir;
    int            errors;
    int            cycles;
    int            src_idle_pct;
    int            snk_stall_pct;
    logic [63:0]   lock_pool[6];

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic lock_result_t mk(logic [2:0] st, logic [1:0] msg, logic [7:0] tgt,
                                        logic [63:0] lk);
        lock_result_t r;
        r.status  = st;
        r.message = msg;
        r.target  = tgt;
        r.lock    = lk;
        r.last    = 1'b0;
        return r;
    endfunction

    function automatic int find_lock(logic [63:0] lk);
        for (int i = 0; i < NENT; i++)
            if (tb_valid[i] && tb_lock[i] == lk) return i;
        return -1;
    endfunction

    task automatic expect_result(lock_result_t r);
        exp_q[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endtask

    // Advance the model by one request and queue the results it causes
    task automatic predict_lock_table(kind_t kind, logic [63:0] lk, logic [7:0] cl);
        int e;
        int n;
        int first;
        first = exp_wr;
        case (kind)
            KIND_ACQUIRE: begin
                e = find_lock(lk);
                if (e < 0) begin
                    n = -1;
                    for (int i = NENT - 1; i >= 0; i--) if (!tb_valid[i]) n = i;
                    if (n < 0) begin
                        expect_result(mk(ST_TABLE_FULL, MSG_NONE, 8'd0, lk));
                    end else begin
                        tb_valid[n] = 1'b1; tb_lock[n] = lk; tb_holder[n] = cl;
                        tb_free[n] = 1'b0; tb_revoked[n] = 1'b0;
                        tb_head[n] = 0; tb_count[n] = 0;
                        expect_result(mk(ST_OK, MSG_NONE, 8'd0, lk));
                    end
                end else if (tb_free[e]) begin
                    tb_holder[e] = cl; tb_free[e] = 1'b0;
                    expect_result(mk(ST_OK, MSG_NONE, 8'd0, lk));
                end else if (tb_count[e] >= QDEPTH) begin
                    expect_result(mk(ST_QUEUE_FULL, MSG_NONE, 8'd0, lk));
                end else begin
                    tb_waiters[e][(tb_head[e] + tb_count[e]) % QDEPTH] = cl;
                    tb_count[e]++;
                    expect_result(mk(ST_RETRY, MSG_NONE, 8'd0, lk));
                end
            end
            KIND_RELEASE: begin
                e = find_lock(lk);
                if (e < 0) begin
                    expect_result(mk(ST_UNKNOWN, MSG_NONE, 8'd0, lk));
                end else begin
                    tb_revoked[e] = 1'b0;
                    if (tb_count[e] == 0) begin
                        tb_free[e] = 1'b1;
                        expect_result(mk(ST_OK, MSG_NONE, 8'd0, lk));
                    end else begin
                        tb_holder[e] = tb_waiters[e][tb_head[e]];
                        tb_head[e] = (tb_head[e] + 1) % QDEPTH;
                        tb_count[e]--;
                        tb_free[e] = 1'b0;
                        expect_result(mk(ST_OK, MSG_GRANT, tb_holder[e], lk));
                    end
                end
            end
            KIND_TICK: begin
                for (int i = 0; i < NENT && (exp_wr - first) < MAX_RESULTS; i++)
                    if (tb_valid[i] && tb_count[i] != 0 && !tb_revoked[i]) begin
                        expect_result(mk(ST_OK, MSG_REVOKE, tb_holder[i], tb_lock[i]));
                        tb_revoked[i] = 1'b1;
                    end
                if (exp_wr == first) expect_result(mk(ST_OK, MSG_NONE, 8'd0, 64'd0));
            end
            default: expect_result(mk(ST_OK, MSG_NONE, 8'd0, 64'd0));
        endcase
        exp_q[(exp_wr - 1) % EXP_DEPTH].last = 1'b1;
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // Check every result transfer against the oldest expected result
    always @(posedge aclk) begin
        lock_result_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (exp_wr == exp_rd) begin
                report_mismatch("unexpected result", m_tdata[63:0], 64'd0);
            end else begin
                w = exp_q[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (m_tdata[2:0] !== w.status)
                    report_mismatch("status", 64'(m_tdata[2:0]), 64'(w.status));
                if (m_tuser !== w.message)
                    report_mismatch("message", 64'(m_tuser), 64'(w.message));
                if (m_tdata[10:3] !== w.target)
                    report_mismatch("target", 64'(m_tdata[10:3]), 64'(w.target));
                if (m_tdata[74:11] !== w.lock)
                    report_mismatch("lock", m_tdata[74:11], w.lock);
                if (m_tlast !== w.last)
                    report_mismatch("last", 64'(m_tlast), 64'(w.last));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else          m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Present one request, hold it until taken, then predict its results; a typed result replaces the last
    task automatic send_request(lock_request_t rq);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq.kind;
        s_tdata  <= {rq.client, rq.lock};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // model is advanced in either case; a typed expectation replaces it
        predict_lock_table(rq.kind, rq.lock, rq.client);
        if (rq.known) exp_q[(exp_wr - 1) % EXP_DEPTH] = rq.res;
    endtask

    task automatic add_row(lock_request_t rq);
        directed[n_dir] = rq;
        n_dir++;
    endtask

    function automatic lock_request_t req(kind_t k, logic [63:0] lk, logic [7:0] cl);
        lock_request_t r;
        r.kind = k; r.lock = lk; r.client = cl; r.known = 1'b0;
        r.res = '0;
        return r;
    endfunction

    function automatic lock_request_t req_known(kind_t k, logic [63:0] lk, logic [7:0] cl,
                                                lock_result_t res);
        lock_request_t r;
        r = req(k, lk, cl);
        r.known = 1'b1;
        r.res = res;
        r.res.last = 1'b1;
        return r;
    endfunction

    function automatic lock_request_t random_request();
        int pick;
        logic [63:0] lk;
        pick = $urandom_range(99);
        lk = (pick % 10 == 0) ? {$urandom, $urandom} : lock_pool[$urandom_range(5)];
        if (pick < 55)      return req(KIND_ACQUIRE, lk, 8'($urandom));
        else if (pick < 85) return req(KIND_RELEASE, lk, 8'($urandom));
        else if (pick < 97) return req(KIND_TICK, {$urandom, $urandom}, 8'($urandom));
        else                return req(KIND_NONE, {$urandom, $urandom}, 8'($urandom));
    endfunction

    initial begin
        lock_request_t rq;
        errors = 0; cycles = 0;
        exp_wr = 0; exp_rd = 0; n_dir = 0;
        src_idle_pct = 0; snk_stall_pct = 0;
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0; s_tuser = KIND_ACQUIRE;
        for (int i = 0; i < NENT; i++) begin
            tb_valid[i] = 1'b0; tb_free[i] = 1'b0; tb_revoked[i] = 1'b0;
            tb_head[i] = 0; tb_count[i] = 0; tb_lock[i] = '0; tb_holder[i] = '0;
        end
        foreach (lock_pool[i]) lock_pool[i] = {$urandom, $urandom};
        lock_pool[0] = '1;
        lock_pool[1] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        add_row(req_known(KIND_TICK, 64'd5, 8'd0, mk(ST_OK, MSG_NONE, 8'd0, 64'd0)));
        add_row(req_known(KIND_RELEASE, '1, 8'd0, mk(ST_UNKNOWN, MSG_NONE, 8'd0, '1)));
        add_row(req_known(KIND_ACQUIRE, '1, 8'hff, mk(ST_OK, MSG_NONE, 8'd0, '1)));
        add_row(req(KIND_ACQUIRE, '1, 8'hff));       // holder asks again
        add_row(req(KIND_ACQUIRE, '1, 8'h00));
        add_row(req(KIND_TICK, '0, 8'd0));
        add_row(req(KIND_TICK, '0, 8'd0));          // already revoked
        add_row(req(KIND_RELEASE, '1, 8'h12));      // non-holder hands on
        add_row(req(KIND_RELEASE, '1, 8'h00));
        add_row(req(KIND_RELEASE, '1, 8'h00));      // now free
        add_row(req(KIND_RELEASE, '1, 8'h00));      // free stays free
        add_row(req_known(KIND_NONE, 64'd9, 8'd3, mk(ST_OK, MSG_NONE, 8'd0, 64'd0)));
        add_row(req(KIND_ACQUIRE, '0, 8'h5a));
        for (int i = 0; i < QDEPTH; i++) add_row(req(KIND_ACQUIRE, '0, 8'(i * 33)));
        add_row(req_known(KIND_ACQUIRE, '0, 8'h77,
                          mk(ST_QUEUE_FULL, MSG_NONE, 8'd0, '0)));
        for (int i = 0; i < n_dir; i++) send_request(directed[i]);

        // fill the table, then table full
        for (int i = 2; i < NENT; i++) begin
            send_request(req(KIND_ACQUIRE, 64'h1000 + i, 8'(i)));
            send_request(req(KIND_ACQUIRE, 64'h1000 + i, 8'(i + 100)));
        end
        send_request(req_known(KIND_ACQUIRE, 64'hdead, 8'd1,
                               mk(ST_TABLE_FULL, MSG_NONE, 8'd0, 64'hdead)));
        send_request(req(KIND_TICK, '0, 8'd0));                // many revokes

        // random phases on a fresh table would need reset; keep the full table
        // but also use its lock ids so traffic stays live
        for (int i = 0; i < 4; i++) lock_pool[2 + i] = 64'h1000 + 2 + $urandom_range(13);
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 49; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 49; end
                default: begin src_idle_pct = 35; snk_stall_pct = 35; end
            endcase
            for (int i = 0; i < N_RANDOM / 4; i++) begin
                rq = random_request();
                send_request(rq);
            end
        end
        s_tvalid <= 1'b0;

        while (exp_wr != exp_rd) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0) $display("ALL CHECKS PASSED");
        else             $display("CHECKS FAILED");
        $finish;
    end
endmodule

FILE: filelist.f
design/ltgq_pkg.sv
design/ltgq_ram.sv
design/ltgq_table.sv
design/lock_table_grant_queue_revoke.sv
dv/tb_top.sv
